// File: src/sps_pkg.sv
package sps_pkg;

  localparam int POS_W      = 32;
  localparam int RATE_W     = 24;
  localparam int ACC_W      = 8;
  localparam int STEP_W     = 8;
  localparam int DIM_W      = 16;
  localparam int DIV_W      = RATE_W + 1;
  localparam int DVSR_W     = STEP_W + 1;
  localparam int DIV_CNT_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DIM_SHIFT  = 11;
  localparam int MOVE_SHIFT = 8;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHADOW_EN  = 2'd3;

  localparam logic [STEP_W-1:0] STEP_RESET = 8'd16;
  localparam logic [POS_W-1:0]  X_MARGIN   = 32'h0000_F000;
  localparam logic [POS_W-1:0]  Y_MARGIN   = 32'h0000_A000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RATE,
    S_DIV,
    S_MOVE,
    S_CLAMP,
    S_DONE
  } sps_state_t;

  typedef struct packed {
    logic load_start;
    logic idle_tick;
    logic div_start;
    logic calc_rate;
    logic move;
    logic clamp;
    logic out_load;
  } sps_cmd_t;

  typedef struct packed {
    logic running;
    logic div_done;
  } sps_stat_t;

endpackage

// File: src/sps_div.sv
module sps_div
  import sps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_W-1:0]     dividend,
  input  logic [DVSR_W-1:0]    divisor,
  output logic                 done,
  output logic [RATE_W-1:0]    quot,
  output logic [ACC_W-1:0]     rem
);

  logic [DIV_W-1:0]     dq_r, dq_nxt;
  logic [ACC_W-1:0]     rem_r, rem_nxt;
  logic [DVSR_W-1:0]    divisor_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DVSR_W-1:0]    trial;
  logic [DVSR_W-1:0]    diff;
  logic                 ge;

  // one quotient bit per cycle, restoring
  assign trial = {rem_r, dq_r[DIV_W-1]};
  assign ge    = (trial >= divisor_r);
  assign diff  = trial - divisor_r;

  always_comb begin
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      dq_nxt   = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      dq_nxt  = {dq_r[DIV_W-2:0], ge};
      rem_nxt = ge ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      divisor_r <= divisor;
    end
  end

  assign done = done_r;
  assign quot = dq_r[RATE_W-1:0];
  assign rem  = rem_r;

`ifndef SYNTH
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ({1'b0, rem_r} < divisor_r))
    else $error("divider remainder not below divisor");

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> ($past(cnt_r) == DIV_LAST) && $past(busy_r))
    else $error("divider done without full iteration count");
`endif

endmodule

// File: src/sps_datapath.sv
module sps_datapath
  import sps_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  sps_cmd_t                cmd,
  output sps_stat_t               status,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic signed [POS_W-1:0] in_start_x,
  input  logic signed [POS_W-1:0] in_start_y,
  input  logic signed [POS_W-1:0] in_start_shadow_x,
  input  logic signed [POS_W-1:0] in_start_shadow_y,
  input  logic signed [POS_W-1:0] in_goal_x,
  input  logic signed [POS_W-1:0] in_goal_y,
  output logic signed [POS_W-1:0] out_pos_x,
  output logic signed [POS_W-1:0] out_pos_y,
  output logic signed [POS_W-1:0] out_shadow_pos_x,
  output logic signed [POS_W-1:0] out_shadow_pos_y,
  output logic                    out_finished
);

  // configuration
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DIM_W-1:0]  width_r, width_nxt;
  logic [DIM_W-1:0]  height_r, height_nxt;
  logic              shadow_en_r, shadow_en_nxt;
  logic [POS_W-1:0]  xlim_r, xlim_nxt;
  logic [POS_W-1:0]  ylim_r, ylim_nxt;

  // pan state
  logic [POS_W-1:0]  cam_x_r, cam_x_nxt, cam_y_r, cam_y_nxt;
  logic [POS_W-1:0]  sh_x_r, sh_x_nxt, sh_y_r, sh_y_nxt;
  logic [RATE_W-1:0] rate_x_r, rate_x_nxt, rate_y_r, rate_y_nxt;
  logic              neg_x_r, neg_x_nxt, neg_y_r, neg_y_nxt;
  logic [ACC_W-1:0]  acc_x_r, acc_x_nxt, acc_y_r, acc_y_nxt;
  logic [STEP_W-1:0] tick_r, tick_nxt;
  logic              running_r, running_nxt;
  logic              fin_r, fin_nxt;
  logic [POS_W-1:0]  dx_r, dx_nxt, dy_r, dy_nxt;

  // result register
  logic [POS_W-1:0]  o_x_r, o_y_r, o_sx_r, o_sy_r;
  logic              o_fin_r;

  // divider lanes
  logic [DIV_W-1:0]  dvd_x, dvd_y;
  logic [DVSR_W-1:0] dvsr;
  logic              done_x, done_y;
  logic [RATE_W-1:0] quot_x, quot_y;
  logic [ACC_W-1:0]  rem_x, rem_y;

  logic [POS_W-1:0]  mag_x, mag_y;
  logic [POS_W-1:0]  delta_x, delta_y;
  logic              gt_x, gt_y, hit_x, hit_y;
  logic [STEP_W-1:0] tick_inc;

  assign dvd_x = {{(DIV_W-RATE_W){1'b0}}, rate_x_r} + {{(DIV_W-ACC_W){1'b0}}, acc_x_r};
  assign dvd_y = {{(DIV_W-RATE_W){1'b0}}, rate_y_r} + {{(DIV_W-ACC_W){1'b0}}, acc_y_r};
  // a step count of zero acts as 256
  assign dvsr  = (step_r == '0) ? {1'b1, {STEP_W{1'b0}}} : {1'b0, step_r};

  sps_div u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd_x),
    .divisor  (dvsr),
    .done     (done_x),
    .quot     (quot_x),
    .rem      (rem_x)
  );

  sps_div u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd_y),
    .divisor  (dvsr),
    .done     (done_y),
    .quot     (quot_y),
    .rem      (rem_y)
  );

  assign mag_x   = dx_r[POS_W-1] ? (~dx_r + 1'b1) : dx_r;
  assign mag_y   = dy_r[POS_W-1] ? (~dy_r + 1'b1) : dy_r;
  assign delta_x = {quot_x, {MOVE_SHIFT{1'b0}}};
  assign delta_y = {quot_y, {MOVE_SHIFT{1'b0}}};
  assign gt_x    = ($signed(cam_x_r) > $signed(xlim_r));
  assign gt_y    = ($signed(cam_y_r) > $signed(ylim_r));
  assign hit_x   = cam_x_r[POS_W-1] || gt_x;
  assign hit_y   = cam_y_r[POS_W-1] || gt_y;
  assign tick_inc = tick_r + 1'b1;

  always_comb begin
    step_nxt      = step_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    shadow_en_nxt = shadow_en_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_STEP_COUNT: step_nxt      = cfg_data[STEP_W-1:0];
        REG_MAP_WIDTH:  width_nxt     = cfg_data[DIM_W-1:0];
        REG_MAP_HEIGHT: height_nxt    = cfg_data[DIM_W-1:0];
        REG_SHADOW_EN:  shadow_en_nxt = cfg_data[0];
        default: ;
      endcase
    end
    xlim_nxt = {{(POS_W-DIM_W-DIM_SHIFT){1'b0}}, width_r, {DIM_SHIFT{1'b0}}} - X_MARGIN;
    ylim_nxt = {{(POS_W-DIM_W-DIM_SHIFT){1'b0}}, height_r, {DIM_SHIFT{1'b0}}} - Y_MARGIN;
  end

  always_comb begin
    cam_x_nxt   = cam_x_r;
    cam_y_nxt   = cam_y_r;
    sh_x_nxt    = sh_x_r;
    sh_y_nxt    = sh_y_r;
    rate_x_nxt  = rate_x_r;
    rate_y_nxt  = rate_y_r;
    neg_x_nxt   = neg_x_r;
    neg_y_nxt   = neg_y_r;
    acc_x_nxt   = acc_x_r;
    acc_y_nxt   = acc_y_r;
    tick_nxt    = tick_r;
    running_nxt = running_r;
    fin_nxt     = fin_r;
    dx_nxt      = dx_r;
    dy_nxt      = dy_r;

    if (cmd.load_start) begin
      cam_x_nxt = in_start_x;
      cam_y_nxt = in_start_y;
      sh_x_nxt  = in_start_shadow_x;
      sh_y_nxt  = in_start_shadow_y;
      dx_nxt    = in_goal_x - in_start_x;
      dy_nxt    = in_goal_y - in_start_y;
    end

    if (cmd.idle_tick) begin
      fin_nxt = 1'b1;
    end

    if (cmd.calc_rate) begin
      // truncate toward zero: magnitude shifted, sign kept only if nonzero
      rate_x_nxt  = mag_x[POS_W-1:MOVE_SHIFT];
      rate_y_nxt  = mag_y[POS_W-1:MOVE_SHIFT];
      neg_x_nxt   = dx_r[POS_W-1] && (mag_x[POS_W-1:MOVE_SHIFT] != '0);
      neg_y_nxt   = dy_r[POS_W-1] && (mag_y[POS_W-1:MOVE_SHIFT] != '0);
      acc_x_nxt   = '0;
      acc_y_nxt   = '0;
      tick_nxt    = '0;
      running_nxt = 1'b1;
      fin_nxt     = 1'b0;
    end

    if (cmd.move) begin
      cam_x_nxt = neg_x_r ? (cam_x_r - delta_x) : (cam_x_r + delta_x);
      cam_y_nxt = neg_y_r ? (cam_y_r - delta_y) : (cam_y_r + delta_y);
      if (shadow_en_r) begin
        sh_x_nxt = neg_x_r ? (sh_x_r - delta_x) : (sh_x_r + delta_x);
        sh_y_nxt = neg_y_r ? (sh_y_r - delta_y) : (sh_y_r + delta_y);
      end
      acc_x_nxt = rem_x;
      acc_y_nxt = rem_y;
    end

    if (cmd.clamp) begin
      if (hit_x) begin
        cam_x_nxt = cam_x_r[POS_W-1] ? '0 : xlim_r;
        if (shadow_en_r) begin
          sh_x_nxt = cam_x_r[POS_W-1] ? '0 : xlim_r;
        end
      end
      if (hit_y) begin
        cam_y_nxt = cam_y_r[POS_W-1] ? '0 : ylim_r;
        if (shadow_en_r) begin
          sh_y_nxt = cam_y_r[POS_W-1] ? '0 : ylim_r;
        end
      end
      if (hit_x && hit_y) begin
        fin_nxt = 1'b1;
      end else begin
        tick_nxt = tick_inc;
        fin_nxt  = (tick_inc == step_r);
      end
      running_nxt = !fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_RESET;
      width_r     <= '0;
      height_r    <= '0;
      shadow_en_r <= 1'b0;
      cam_x_r     <= '0;
      cam_y_r     <= '0;
      sh_x_r      <= '0;
      sh_y_r      <= '0;
      rate_x_r    <= '0;
      rate_y_r    <= '0;
      neg_x_r     <= 1'b0;
      neg_y_r     <= 1'b0;
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      tick_r      <= '0;
      running_r   <= 1'b0;
      fin_r       <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      shadow_en_r <= shadow_en_nxt;
      cam_x_r     <= cam_x_nxt;
      cam_y_r     <= cam_y_nxt;
      sh_x_r      <= sh_x_nxt;
      sh_y_r      <= sh_y_nxt;
      rate_x_r    <= rate_x_nxt;
      rate_y_r    <= rate_y_nxt;
      neg_x_r     <= neg_x_nxt;
      neg_y_r     <= neg_y_nxt;
      acc_x_r     <= acc_x_nxt;
      acc_y_r     <= acc_y_nxt;
      tick_r      <= tick_nxt;
      running_r   <= running_nxt;
      fin_r       <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    xlim_r <= xlim_nxt;
    ylim_r <= ylim_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    if (cmd.out_load) begin
      o_x_r   <= cam_x_r;
      o_y_r   <= cam_y_r;
      o_sx_r  <= sh_x_r;
      o_sy_r  <= sh_y_r;
      o_fin_r <= fin_r;
    end
  end

  assign status.running  = running_r;
  assign status.div_done = done_x && done_y;

  assign out_pos_x        = o_x_r;
  assign out_pos_y        = o_y_r;
  assign out_shadow_pos_x = o_sx_r;
  assign out_shadow_pos_y = o_sy_r;
  assign out_finished     = o_fin_r;

`ifndef SYNTH
  a_running_ends_on_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(running_r) |-> $past(cmd.clamp))
    else $error("pan stopped outside the clamp step");
`endif

endmodule

// File: src/sps_ctrl.sv
module sps_ctrl
  import sps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_op,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  sps_stat_t status,
  output sps_cmd_t  cmd
);

  sps_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       out_free;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op == OP_START) begin
            state_nxt = S_RATE;
          end else if (status.running) begin
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_RATE:  state_nxt = S_DONE;
      S_DIV: begin
        if (status.div_done) begin
          state_nxt = S_MOVE;
        end
      end
      S_MOVE:  state_nxt = S_CLAMP;
      S_CLAMP: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load_start = (in_op == OP_START);
          cmd.div_start  = (in_op == OP_TICK) && status.running;
          cmd.idle_tick  = (in_op == OP_TICK) && !status.running;
        end
      end
      S_RATE:  cmd.calc_rate = 1'b1;
      S_MOVE:  cmd.move      = 1'b1;
      S_CLAMP: cmd.clamp     = 1'b1;
      S_DONE:  cmd.out_load  = out_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_move_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE) |-> ($past(state_r) == S_DIV) && $past(status.div_done))
    else $error("move step entered before both quotients were ready");

  a_rate_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RATE) |-> $past(cmd.load_start))
    else $error("rate step without a start item");
`endif

endmodule

// File: src/scroll_pan_stepper.sv
// Flow: a start item goes through the rate step to the done state, a tick while idle
// goes straight to done, and a tick while panning waits in the divide state for the
// bit-serial divide of each axis's rate plus accumulator by the step count (both axes
// side by side), then moves and clamps. One item is in work at a time; the next is taken
// the cycle after the result is registered, while that result may still wait at the output.
// Reset (rst_n low, synchronous) idles the block, clears positions and loads defaults.
module scroll_pan_stepper
  import sps_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_op,
  input  logic signed [POS_W-1:0] in_start_x,
  input  logic signed [POS_W-1:0] in_start_y,
  input  logic signed [POS_W-1:0] in_start_shadow_x,
  input  logic signed [POS_W-1:0] in_start_shadow_y,
  input  logic signed [POS_W-1:0] in_goal_x,
  input  logic signed [POS_W-1:0] in_goal_y,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [POS_W-1:0] out_pos_x,
  output logic signed [POS_W-1:0] out_pos_y,
  output logic signed [POS_W-1:0] out_shadow_pos_x,
  output logic signed [POS_W-1:0] out_shadow_pos_y,
  output logic                    out_finished,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  sps_cmd_t  cmd;
  sps_stat_t status;

  assign cfg_ready = 1'b1;

  sps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  sps_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_start_x        (in_start_x),
    .in_start_y        (in_start_y),
    .in_start_shadow_x (in_start_shadow_x),
    .in_start_shadow_y (in_start_shadow_y),
    .in_goal_x         (in_goal_x),
    .in_goal_y         (in_goal_y),
    .out_pos_x         (out_pos_x),
    .out_pos_y         (out_pos_y),
    .out_shadow_pos_x  (out_shadow_pos_x),
    .out_shadow_pos_y  (out_shadow_pos_y),
    .out_finished      (out_finished)
  );

endmodule

// File: dv/scroll_pan_stepper_tb.sv
`timescale 1ns / 100ps

module scroll_pan_stepper_tb
  import sps_pkg::*;
();

  localparam int CYCLE_LIMIT = 800000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 75;

  typedef struct packed {
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
    logic [POS_W-1:0] sx;
    logic [POS_W-1:0] sy;
    logic             fin;
  } pan_result_t;

  class pan_scoreboard;
    bit [STEP_W-1:0] step_reg;
    bit [DIM_W-1:0]  width_reg, height_reg;
    bit              shadow_on;
    bit [POS_W-1:0]  cam_x, cam_y, shd_x, shd_y, acc_x, acc_y;
    bit [RATE_W-1:0] rate_x, rate_y;
    bit              neg_x, neg_y, running;
    bit [7:0]        ticks;
    pan_result_t     expected_q[$];
    int n_errors, n_checked, n_starts, n_ticks, n_idle_ticks, n_ends, n_clamp_ends;

    function void clear();
      step_reg = STEP_RESET;
      width_reg = '0;
      height_reg = '0;
      shadow_on = 1'b0;
      {cam_x, cam_y, shd_x, shd_y, acc_x, acc_y} = '0;
      {rate_x, rate_y, neg_x, neg_y, ticks, running} = '0;
      expected_q.delete();
    endfunction

    function void store_reg(input bit [CFG_IDX_W-1:0] idx, input bit [CFG_DATA_W-1:0] data);
      case (idx)
        REG_STEP_COUNT: step_reg = data[STEP_W-1:0];
        REG_MAP_WIDTH:  width_reg = data;
        REG_MAP_HEIGHT: height_reg = data;
        REG_SHADOW_EN:  shadow_on = data[0];
        default: ;
      endcase
    endfunction

    function bit [POS_W-1:0] x_limit();
      return (32'(width_reg) << DIM_SHIFT) - X_MARGIN;
    endfunction

    function bit [POS_W-1:0] y_limit();
      return (32'(height_reg) << DIM_SHIFT) - Y_MARGIN;
    endfunction

    // Rate is |delta| / 256 truncated toward zero; small negative deltas end up at zero, +.
    function void aim(input bit [POS_W-1:0] goal, input bit [POS_W-1:0] pos,
                      output bit [RATE_W-1:0] rate, output bit neg);
      bit [POS_W-1:0] d, q;
      d = goal - pos;
      if (d[31]) d = d + 32'hFF;
      q = {{8{d[31]}}, d[31:8]};
      neg = q[31];
      if (neg) q = -q;
      rate = q[RATE_W-1:0];
    endfunction

    function void move_axis(inout bit [POS_W-1:0] acc, inout bit [POS_W-1:0] pos,
                            inout bit [POS_W-1:0] shd, input bit [RATE_W-1:0] rate,
                            input bit neg, input bit [POS_W-1:0] step);
      bit [POS_W-1:0] n, delta;
      acc = acc + 32'(rate);
      n = acc / step;
      acc = acc - n * step;
      delta = n << MOVE_SHIFT;
      if (neg) delta = -delta;
      pos = pos + delta;
      if (shadow_on) shd = shd + delta;
    endfunction

    function bit clamp_axis(inout bit [POS_W-1:0] pos, inout bit [POS_W-1:0] shd,
                            input bit [POS_W-1:0] lim);
      if (pos[31]) begin
        pos = '0;
        if (shadow_on) shd = '0;
        return 1'b1;
      end
      if ($signed(pos) > $signed(lim)) begin
        pos = lim;
        if (shadow_on) shd = lim;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_item(input bit op, input bit [POS_W-1:0] sx, input bit [POS_W-1:0] sy,
                            input bit [POS_W-1:0] ssx, input bit [POS_W-1:0] ssy,
                            input bit [POS_W-1:0] gx, input bit [POS_W-1:0] gy);
      pan_result_t r;
      bit [POS_W-1:0] step;
      int hits;
      bit fin;
      fin = 1'b0;
      if (op == OP_START) begin
        cam_x = sx;
        cam_y = sy;
        shd_x = ssx;
        shd_y = ssy;
        aim(gx, cam_x, rate_x, neg_x);
        aim(gy, cam_y, rate_y, neg_y);
        acc_x = '0;
        acc_y = '0;
        ticks = '0;
        running = 1'b1;
        n_starts++;
      end else if (!running) begin
        fin = 1'b1;
        n_idle_ticks++;
      end else begin
        // zero step count stands for 256
        step = (step_reg == 0) ? 32'd256 : 32'(step_reg);
        move_axis(acc_x, cam_x, shd_x, rate_x, neg_x, step);
        move_axis(acc_y, cam_y, shd_y, rate_y, neg_y, step);
        hits = clamp_axis(cam_x, shd_x, x_limit());
        hits += clamp_axis(cam_y, shd_y, y_limit());
        if (hits == 2) begin
          fin = 1'b1;
          n_clamp_ends++;
        end else begin
          ticks = ticks + 8'd1;
          if (ticks == step_reg) fin = 1'b1;
        end
        if (fin) begin
          running = 1'b0;
          n_ends++;
        end
        n_ticks++;
      end
      r.px = cam_x;
      r.py = cam_y;
      r.sx = shd_x;
      r.sy = shd_y;
      r.fin = fin;
      expected_q.push_back(r);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(input string msg);
      if (n_errors < 40) $display("MISMATCH @%0t: %s", $time, msg);
      n_errors++;
    endtask

    task check_result(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                      input logic [POS_W-1:0] sx, input logic [POS_W-1:0] sy,
                      input logic fin);
      pan_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result x=%h y=%h fin=%b", px, py, fin));
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      if (px !== want.px)
        report($sformatf("result %0d pos_x got %h want %h", n_checked, px, want.px));
      if (py !== want.py)
        report($sformatf("result %0d pos_y got %h want %h", n_checked, py, want.py));
      if (sx !== want.sx)
        report($sformatf("result %0d shadow_pos_x got %h want %h", n_checked, sx, want.sx));
      if (sy !== want.sy)
        report($sformatf("result %0d shadow_pos_y got %h want %h", n_checked, sy, want.sy));
      if (fin !== want.fin)
        report($sformatf("result %0d finished got %b want %b", n_checked, fin, want.fin));
    endtask
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_op;
  logic signed [POS_W-1:0] in_start_x;
  logic signed [POS_W-1:0] in_start_y;
  logic signed [POS_W-1:0] in_start_shadow_x;
  logic signed [POS_W-1:0] in_start_shadow_y;
  logic signed [POS_W-1:0] in_goal_x;
  logic signed [POS_W-1:0] in_goal_y;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [POS_W-1:0] out_pos_x;
  logic signed [POS_W-1:0] out_pos_y;
  logic signed [POS_W-1:0] out_shadow_pos_x;
  logic signed [POS_W-1:0] out_shadow_pos_y;
  logic                    out_finished;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  pan_scoreboard sb;
  bit gaps_on;
  bit bp_on;
  int n_sent;
  int n_settings;
  int cycle_cnt;

  scroll_pan_stepper uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_start_shadow_x(in_start_shadow_x),
    .in_start_shadow_y(in_start_shadow_y),
    .in_goal_x        (in_goal_x),
    .in_goal_y        (in_goal_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_shadow_pos_x (out_shadow_pos_x),
    .out_shadow_pos_y (out_shadow_pos_y),
    .out_finished     (out_finished),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_pos_x, out_pos_y, out_shadow_pos_x, out_shadow_pos_y, out_finished);
  end

  // Result side back-pressure: short stalls mostly, the odd long one.
  initial begin : stall_gen
    int run_left;
    bit hold;
    out_stall = 1'b0;
    run_left = 0;
    forever begin
      @(negedge clk);
      if (run_left == 0) begin
        hold = bp_on && ($urandom_range(0, 2) == 0);
        if (hold)
          run_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(20, 60);
        else
          run_left = $urandom_range(1, 8);
        out_stall = hold;
      end
      run_left--;
    end
  end

  // Leaves valid high on return so the next item can follow back to back.
  task automatic send_item(input bit op, input bit [POS_W-1:0] sx, input bit [POS_W-1:0] sy,
                           input bit [POS_W-1:0] ssx, input bit [POS_W-1:0] ssy,
                           input bit [POS_W-1:0] gx, input bit [POS_W-1:0] gy);
    int gap;
    int r;
    gap = 0;
    r = $urandom_range(0, 99);
    if (gaps_on) begin
      if (r >= 95) gap = $urandom_range(20, 60);
      else if (r >= 85) gap = $urandom_range(4, 10);
      else if (r >= 50) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_op = op;
    in_start_x = sx;
    in_start_y = sy;
    in_start_shadow_x = ssx;
    in_start_shadow_y = ssy;
    in_goal_x = gx;
    in_goal_y = gy;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(op, sx, sy, ssx, ssy, gx, gy);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.store_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_all(input bit [STEP_W-1:0] stp, input bit [DIM_W-1:0] w,
                         input bit [DIM_W-1:0] h, input bit sh);
    wait_idle();
    set_reg(REG_STEP_COUNT, CFG_DATA_W'(stp));
    set_reg(REG_MAP_WIDTH, w);
    set_reg(REG_MAP_HEIGHT, h);
    set_reg(REG_SHADOW_EN, CFG_DATA_W'(sh));
    n_settings++;
  endtask

  // Mostly inside the map, some near either wall, some anywhere.
  function automatic bit [POS_W-1:0] pick_coord(input bit [POS_W-1:0] lim);
    bit [POS_W-1:0] span;
    int r;
    span = ($signed(lim) > 0) ? lim : 32'd8192;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(0, span);
    if (r < 78) return lim + $urandom_range(0, 1024) - 32'd512;
    if (r < 90) return $urandom_range(0, 1024) - 32'd512;
    return $urandom();
  endfunction

  task automatic send_tick();
    send_item(OP_TICK, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
  endtask

  task automatic run_pan();
    bit [POS_W-1:0] xl, yl;
    int cap;
    int k;
    xl = sb.x_limit();
    yl = sb.y_limit();
    send_item(OP_START, pick_coord(xl), pick_coord(yl), pick_coord(xl), pick_coord(yl),
              pick_coord(xl), pick_coord(yl));
    // now and then cut the pan short and restart
    cap = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : 100000;
    k = 0;
    while (sb.running && k < cap) begin
      send_tick();
      k++;
    end
    if ($urandom_range(0, 3) == 0) send_tick();
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 3);
    repeat (n)
      send_item(1'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(),
                $urandom(), $urandom());
  endtask

  initial begin : main
    int p;
    int base;
    bit [STEP_W-1:0] stp;
    bit [DIM_W-1:0] w, h;
    bit sh;

    sb = new();
    sb.clear();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_START;
    in_start_x = '0;
    in_start_y = '0;
    in_start_shadow_x = '0;
    in_start_shadow_y = '0;
    in_goal_x = '0;
    in_goal_y = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_STEP_COUNT;
    cfg_data = '0;
    gaps_on = 1'b1;
    bp_on = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    n_settings = 1;

    // Register defaults give negative limits: any pan tick clamps both axes.
    send_tick();
    send_item(OP_START, 32'd100, 32'd200, 32'd300, 32'd400, 32'd5000, 32'd6000);
    send_tick();
    send_tick();

    set_all(8'd4, 16'd100, 16'd100, 1'b1);
    // small negative delta on x: rate zero, moving +
    send_item(OP_START, 32'd1000, 32'd2000, 32'd5000, 32'd6000, 32'd900, 32'd42000);
    repeat (4) send_tick();
    send_item(OP_START, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h8000_0000, 32'h7FFF_FFFF);
    send_tick();
    // x runs below zero, y past the map edge
    send_item(OP_START, 32'd10000, 32'd10000, 32'd0, 32'd0, 32'hFFFF_3CB0, 32'd400000);
    repeat (4) send_tick();
    send_item(OP_START, 32'd20000, 32'd30000, 32'd1, 32'd2, 32'd140000, 32'd100);
    send_item(OP_START, 32'd50000, 32'd60000, 32'hFFFF_FFFF, 32'h8000_0001, 32'd0, 32'd160000);
    send_tick();
    send_tick();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin stp = 8'd1; w = 16'hFFFF; h = 16'hFFFF; sh = 1'b1; end
        1: begin stp = 8'd255; w = '0; h = '0; sh = 1'b0; end
        2: begin
          stp = 8'd0;
          w = 16'($urandom_range(30, 300));
          h = 16'($urandom_range(30, 300));
          sh = 1'b1;
        end
        default: begin
          stp = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) :
                                              8'($urandom_range(1, 24));
          w = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(20, 400));
          h = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(20, 400));
          sh = 1'($urandom());
        end
      endcase
      set_all(stp, w, h, sh);
      gaps_on = (p % 3 != 1);
      bp_on = (p % 3 != 1);
      base = n_sent;
      while (n_sent - base < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 8) run_pan();
        else send_noise();
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    $display("Sent %0d items over %0d register settings: %0d starts, %0d pan ticks, %0d idle ticks.",
             n_sent, n_settings, sb.n_starts, sb.n_ticks, sb.n_idle_ticks);
    $display("%0d pans ended (%0d with both axes clamped); %0d results compared.",
             sb.n_ends, sb.n_clamp_ends, sb.n_checked);
    if (sb.n_errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
src/sps_pkg.sv
src/sps_div.sv
src/sps_datapath.sv
src/sps_ctrl.sv
src/scroll_pan_stepper.sv
dv/scroll_pan_stepper_tb.sv
